[rtl/core/ffha_pkg.sv]
// Shared command codes and status bundle of the first-fit heap allocator.
package ffha_pkg;

   typedef logic [4:0] ffha_cmd_type;

   localparam ffha_cmd_type CMD_NONE    = 5'd0;
   localparam ffha_cmd_type CMD_CLEAR   = 5'd1;
   localparam ffha_cmd_type CMD_LOAD    = 5'd2;
   localparam ffha_cmd_type CMD_DECODE  = 5'd3;
   localparam ffha_cmd_type CMD_AREAD   = 5'd4;
   localparam ffha_cmd_type CMD_ACHECK  = 5'd5;
   localparam ffha_cmd_type CMD_AUNLINK = 5'd6;
   localparam ffha_cmd_type CMD_AWRBLK  = 5'd7;
   localparam ffha_cmd_type CMD_FREAD   = 5'd8;
   localparam ffha_cmd_type CMD_FCHECK  = 5'd9;
   localparam ffha_cmd_type CMD_IREAD   = 5'd10;
   localparam ffha_cmd_type CMD_IADV    = 5'd11;
   localparam ffha_cmd_type CMD_IMERGE1 = 5'd12;
   localparam ffha_cmd_type CMD_IMERGE2 = 5'd13;
   localparam ffha_cmd_type CMD_IWRG    = 5'd14;
   localparam ffha_cmd_type CMD_IWRIT   = 5'd15;
   localparam ffha_cmd_type CMD_RSP     = 5'd16;

   typedef struct packed {
      logic clr_last;
      logic is_free;
      logic pre_ok;
      logic cur_past;
      logic found;
      logic found_end;
      logic split;
      logic ins_stop;
      logic free_valid;
   } ffha_status_type;

endpackage

[rtl/core/ffha_ctrl.sv]
// Sequencer of the first-fit heap allocator: walks, unlink, insert and result transfer.
module ffha_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  ffha_pkg::ffha_status_type status,
   output ffha_pkg::ffha_cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_AREAD   = 4'd3;
   localparam logic [3:0] S_ACHECK  = 4'd4;
   localparam logic [3:0] S_AUNLINK = 4'd5;
   localparam logic [3:0] S_AWRBLK  = 4'd6;
   localparam logic [3:0] S_FREAD   = 4'd7;
   localparam logic [3:0] S_FCHECK  = 4'd8;
   localparam logic [3:0] S_IWALK   = 4'd9;
   localparam logic [3:0] S_IADV    = 4'd10;
   localparam logic [3:0] S_IMERGE2 = 4'd11;
   localparam logic [3:0] S_IWRG    = 4'd12;
   localparam logic [3:0] S_IWRIT   = 4'd13;
   localparam logic [3:0] S_DONE    = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_load;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      cmd      = ffha_pkg::CMD_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd = ffha_pkg::CMD_CLEAR;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd      = ffha_pkg::CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd = ffha_pkg::CMD_DECODE;
            if (!status.pre_ok) state_in = S_DONE;
            else if (status.is_free) state_in = S_FREAD;
            else state_in = S_AREAD;
         end
         S_AREAD: begin
            if (status.cur_past) state_in = S_DONE;
            else begin
               cmd      = ffha_pkg::CMD_AREAD;
               state_in = S_ACHECK;
            end
         end
         S_ACHECK: begin
            cmd = ffha_pkg::CMD_ACHECK;
            if (status.found) state_in = status.found_end ? S_DONE : S_AUNLINK;
            else state_in = S_AREAD;
         end
         S_AUNLINK: begin
            cmd      = ffha_pkg::CMD_AUNLINK;
            state_in = S_AWRBLK;
         end
         S_AWRBLK: begin
            cmd      = ffha_pkg::CMD_AWRBLK;
            state_in = status.split ? S_IWALK : S_DONE;
         end
         S_FREAD: begin
            cmd      = ffha_pkg::CMD_FREAD;
            state_in = S_FCHECK;
         end
         S_FCHECK: begin
            cmd      = ffha_pkg::CMD_FCHECK;
            state_in = status.free_valid ? S_IWALK : S_DONE;
         end
         S_IWALK: begin
            if (status.ins_stop) begin
               cmd      = ffha_pkg::CMD_IMERGE1;
               state_in = S_IMERGE2;
            end else begin
               cmd      = ffha_pkg::CMD_IREAD;
               state_in = S_IADV;
            end
         end
         S_IADV: begin
            cmd      = ffha_pkg::CMD_IADV;
            state_in = S_IWALK;
         end
         S_IMERGE2: begin
            cmd      = ffha_pkg::CMD_IMERGE2;
            state_in = S_IWRG;
         end
         S_IWRG: begin
            cmd      = ffha_pkg::CMD_IWRG;
            state_in = S_IWRIT;
         end
         S_IWRIT: begin
            cmd      = ffha_pkg::CMD_IWRIT;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               cmd      = ffha_pkg::CMD_RSP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("request taken during clearing pass");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DECODE))
      else $error("accepted request not decoded");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not presented after completion");

endmodule

[rtl/core/ffha_datapath.sv]
// Header memory, list registers and arithmetic of the first-fit heap allocator.
module ffha_datapath #(
   parameter int POOL_BYTES   = 4096,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ffha_pkg::ffha_cmd_type    cmd,
   output ffha_pkg::ffha_status_type status,
   input  logic                      csr_write_enable,
   input  logic [12:0]               csr_write_data,
   input  logic                      req_operation,
   input  logic [15:0]               req_request_bytes,
   input  logic [11:0]               req_user_address,
   output logic                      rsp_ok,
   output logic [11:0]               rsp_granted_address,
   output logic [12:0]               rsp_block_bytes,
   output logic [12:0]               rsp_free_bytes
);

   localparam int HDR      = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int GRANULES = POOL_BYTES / ALIGN_BYTES;
   localparam int END_G    = GRANULES - HDR / ALIGN_BYTES;
   localparam int IW       = $clog2(GRANULES);
   localparam int GW       = $clog2(GRANULES + 1);
   localparam int SW       = $clog2(POOL_BYTES + 1);
   localparam int AW       = $clog2(ALIGN_BYTES);
   localparam int TW       = ((SW > 17) ? SW : 17) + 1;
   localparam int BW       = SW + 1;
   localparam logic [GW-1:0] SENT    = GW'(GRANULES);
   localparam logic [GW-1:0] END_IDX = GW'(END_G);

   typedef struct packed {
      logic [SW-1:0] size;
      logic [GW-1:0] next;
      logic          has_next;
      logic          alloc;
   } hdr_type;

   function automatic logic [BW-1:0] byte_of(input logic [GW-1:0] gr);
      return BW'(gr) << AW;
   endfunction

   hdr_type mem [GRANULES];
   hdr_type rdata_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   hdr_type       mem_wdata;

   logic          op_ff;
   logic [15:0]   req_ff;
   logic [11:0]   addr_ff;
   logic [TW-1:0] total_ff;
   logic [GW-1:0] cur_ff, prev_ff, blk_ff, g_ff, it_ff, head_ff;
   hdr_type       prev_hdr_ff, h_ff, g_hdr_ff, it_hdr_ff;
   logic          blk_is_it_ff, split_ff;
   logic [SW-1:0] free_rem_ff;
   logic [12:0]   min_split_ff;
   logic [IW-1:0] clr_cnt_ff;
   logic          res_ok_ff;
   logic [11:0]   res_granted_ff;
   logic [SW-1:0] res_bytes_ff;
   logic          rsp_ok_ff;
   logic [11:0]   rsp_granted_ff;
   logic [12:0]   rsp_block_ff, rsp_free_ff;

   logic [TW-1:0] total_c, rem_c;
   logic [12:0]   off_c, g_calc;
   logic          alloc_pre, free_pre, found_c, split_c, it_adj_c, nx_adj_c;
   logic [31:0]   ng_c;
   logic [GW-1:0] unlink_next_c, blk_c;
   logic [SW-1:0] blk_size_c;
   hdr_type       clr_word_c;

   assign total_c = (TW'(req_request_bytes) + TW'(HDR + ALIGN_BYTES - 1)) & ~TW'(ALIGN_BYTES - 1);
   assign alloc_pre = (req_ff != 16'd0) && (total_ff <= TW'(free_rem_ff));
   assign off_c  = {1'b0, addr_ff} - 13'(HDR);
   assign g_calc = off_c >> AW;
   assign free_pre = (addr_ff != 12'd0) && (32'(addr_ff) >= HDR) &&
                     ((off_c & 13'(ALIGN_BYTES - 1)) == 13'd0) && (32'(g_calc) < GRANULES);
   assign found_c = (TW'(rdata_ff.size) >= total_ff) || !rdata_ff.has_next;
   assign rem_c   = TW'(h_ff.size) - total_ff;
   assign ng_c    = 32'(blk_ff) + 32'(total_ff >> AW);
   assign split_c = (rem_c > TW'(min_split_ff)) && (ng_c < GRANULES);
   assign unlink_next_c = h_ff.has_next ? h_ff.next : SENT;
   assign it_adj_c = (it_ff != SENT) &&
                     (byte_of(it_ff) + BW'(it_hdr_ff.size) == byte_of(g_ff));
   assign blk_c      = blk_is_it_ff ? it_ff : g_ff;
   assign blk_size_c = blk_is_it_ff ? it_hdr_ff.size : g_hdr_ff.size;
   assign nx_adj_c = (cur_ff < SENT) && (cur_ff != END_IDX) &&
                     (byte_of(blk_c) + BW'(blk_size_c) == byte_of(cur_ff));

   always_comb begin
      clr_word_c = '0;
      if (clr_cnt_ff == '0) begin
         clr_word_c.size     = SW'(END_G * ALIGN_BYTES);
         clr_word_c.next     = END_IDX;
         clr_word_c.has_next = 1'b1;
      end
   end

   always_comb begin
      status.clr_last   = (clr_cnt_ff == IW'(GRANULES - 1));
      status.is_free    = op_ff;
      status.pre_ok     = op_ff ? free_pre : alloc_pre;
      status.cur_past   = (cur_ff >= SENT);
      status.found      = found_c;
      status.found_end  = (cur_ff == END_IDX);
      status.split      = split_ff;
      status.ins_stop   = (cur_ff >= g_ff) || (cur_ff >= SENT);
      status.free_valid = rdata_ff.alloc && !rdata_ff.has_next;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = clr_word_c;
      mem_raddr = cur_ff[IW-1:0];
      case (cmd)
         ffha_pkg::CMD_CLEAR: mem_we = 1'b1;
         ffha_pkg::CMD_FREAD: mem_raddr = g_ff[IW-1:0];
         ffha_pkg::CMD_AUNLINK: begin
            mem_we             = (prev_ff != SENT);
            mem_waddr          = prev_ff[IW-1:0];
            mem_wdata          = prev_hdr_ff;
            mem_wdata.next     = unlink_next_c;
            mem_wdata.has_next = 1'b1;
         end
         ffha_pkg::CMD_AWRBLK: begin
            mem_we             = 1'b1;
            mem_waddr          = blk_ff[IW-1:0];
            mem_wdata          = h_ff;
            mem_wdata.alloc    = 1'b1;
            mem_wdata.has_next = 1'b0;
         end
         ffha_pkg::CMD_IWRG: begin
            mem_we    = 1'b1;
            mem_waddr = g_ff[IW-1:0];
            mem_wdata = g_hdr_ff;
         end
         ffha_pkg::CMD_IWRIT: begin
            mem_we    = (it_ff != SENT);
            mem_waddr = it_ff[IW-1:0];
            mem_wdata = it_hdr_ff;
            if (!blk_is_it_ff) begin
               mem_wdata.next     = g_ff;
               mem_wdata.has_next = 1'b1;
            end
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[mem_raddr];
   end

   // control state: list head, free count, split threshold, clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         free_rem_ff  <= SW'(END_G * ALIGN_BYTES);
         min_split_ff <= 13'd16;
         clr_cnt_ff   <= '0;
      end else begin
         if (csr_write_enable) min_split_ff <= csr_write_data;
         case (cmd)
            ffha_pkg::CMD_CLEAR: clr_cnt_ff <= clr_cnt_ff + 1'b1;
            ffha_pkg::CMD_AUNLINK: if (prev_ff == SENT) head_ff <= unlink_next_c;
            ffha_pkg::CMD_AWRBLK: free_rem_ff <= free_rem_ff - h_ff.size;
            ffha_pkg::CMD_FCHECK:
               if (status.free_valid) free_rem_ff <= free_rem_ff + rdata_ff.size;
            ffha_pkg::CMD_IWRIT: if (it_ff == SENT) head_ff <= g_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         ffha_pkg::CMD_LOAD: begin
            op_ff          <= req_operation;
            req_ff         <= req_request_bytes;
            addr_ff        <= req_user_address;
            total_ff       <= total_c;
            res_ok_ff      <= 1'b0;
            res_granted_ff <= '0;
            res_bytes_ff   <= '0;
         end
         ffha_pkg::CMD_DECODE: begin
            cur_ff  <= head_ff;
            prev_ff <= SENT;
            g_ff    <= GW'(g_calc);
         end
         ffha_pkg::CMD_ACHECK: begin
            if (found_c) begin
               h_ff   <= rdata_ff;
               blk_ff <= cur_ff;
            end else begin
               prev_ff     <= cur_ff;
               prev_hdr_ff <= rdata_ff;
               cur_ff      <= rdata_ff.next;
            end
         end
         ffha_pkg::CMD_AUNLINK: begin
            split_ff <= split_c;
            if (split_c) begin
               g_ff              <= GW'(ng_c);
               g_hdr_ff.size     <= SW'(rem_c);
               g_hdr_ff.next     <= h_ff.next;
               g_hdr_ff.has_next <= 1'b0;
               g_hdr_ff.alloc    <= 1'b0;
               h_ff.size         <= SW'(total_ff);
            end
         end
         ffha_pkg::CMD_AWRBLK: begin
            res_ok_ff      <= 1'b1;
            res_granted_ff <= 12'(byte_of(blk_ff) + BW'(HDR));
            res_bytes_ff   <= h_ff.size;
            cur_ff         <= head_ff;
            it_ff          <= SENT;
         end
         ffha_pkg::CMD_FCHECK: begin
            if (status.free_valid) begin
               g_hdr_ff       <= '{size: rdata_ff.size, next: rdata_ff.next,
                                   has_next: rdata_ff.has_next, alloc: 1'b0};
               res_ok_ff      <= 1'b1;
               res_bytes_ff   <= rdata_ff.size;
               cur_ff         <= head_ff;
               it_ff          <= SENT;
            end
         end
         ffha_pkg::CMD_IADV: begin
            it_ff     <= cur_ff;
            it_hdr_ff <= rdata_ff;
            cur_ff    <= rdata_ff.has_next ? rdata_ff.next : SENT;
         end
         ffha_pkg::CMD_IMERGE1: begin
            // merge into the lower neighbor, or link the block ahead of the next one
            blk_is_it_ff <= it_adj_c;
            if (it_adj_c) it_hdr_ff.size <= it_hdr_ff.size + g_hdr_ff.size;
            else begin
               g_hdr_ff.next     <= cur_ff;
               g_hdr_ff.has_next <= 1'b1;
            end
         end
         ffha_pkg::CMD_IMERGE2: begin
            if (nx_adj_c) begin
               if (blk_is_it_ff) begin
                  it_hdr_ff.size     <= it_hdr_ff.size + rdata_ff.size;
                  it_hdr_ff.next     <= rdata_ff.next;
                  it_hdr_ff.has_next <= rdata_ff.has_next;
               end else begin
                  g_hdr_ff.size     <= g_hdr_ff.size + rdata_ff.size;
                  g_hdr_ff.next     <= rdata_ff.next;
                  g_hdr_ff.has_next <= rdata_ff.has_next;
               end
            end
         end
         ffha_pkg::CMD_RSP: begin
            rsp_ok_ff      <= res_ok_ff;
            rsp_granted_ff <= res_granted_ff;
            rsp_block_ff   <= 13'(res_bytes_ff);
            rsp_free_ff    <= 13'(free_rem_ff);
         end
         default: ;
      endcase
   end

   assign rsp_ok              = rsp_ok_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_block_bytes     = rsp_block_ff;
   assign rsp_free_bytes      = rsp_free_ff;

endmodule

[rtl/core/first_fit_heap_allocator.sv]
// Top level of the first-fit coalescing heap allocator.
// Usage: a request (operation, request_bytes, user_address) transfers when
// req_valid is high and req_stall low. Allocate (operation 0) searches the
// address-ordered free list first-fit, splits off a remainder larger than
// min_split_bytes, and returns the user address. Free (operation 1) checks
// the header and reinserts the block, merging with both neighbors.
// Each request yields exactly one result on rsp_*, transferred when
// rsp_valid is high and rsp_stall low; the result register holds while
// stalled, and a new request is taken while a result still waits.
// Latency from request transfer to rsp_valid grows with the free-list
// nodes walked, set by the single-port header memory with registered read
// (one header read per visited node). A split allocate or a valid free
// walks the list a second time, up to the insertion point. Throughput: one
// request at a time; the next transfer can happen at the edge after the
// result is loaded. Reset: a clearing pass writes every header and builds
// one large free block and the end marker; requests are stalled during it.
// csr_write_enable writes min_split_bytes; the user must do so only while
// idle, since the block itself does not enforce it.
module first_fit_heap_allocator #(
   parameter int POOL_BYTES   = 4096,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [12:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_request_bytes,
   input  logic [11:0] req_user_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [11:0] rsp_granted_address,
   output logic [12:0] rsp_block_bytes,
   output logic [12:0] rsp_free_bytes
);

   ffha_pkg::ffha_cmd_type    cmd;
   ffha_pkg::ffha_status_type status;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ffha_datapath #(
      .POOL_BYTES   (POOL_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_operation       (req_operation),
      .req_request_bytes   (req_request_bytes),
      .req_user_address    (req_user_address),
      .rsp_ok              (rsp_ok),
      .rsp_granted_address (rsp_granted_address),
      .rsp_block_bytes     (rsp_block_bytes),
      .rsp_free_bytes      (rsp_free_bytes)
   );

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the first-fit coalescing heap allocator.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_BYTES = 4096;
   localparam int ALIGN_BYTES = 8;
   localparam int HEADER_BYTES = 8;
   localparam int HDR = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int GRANULES = POOL_BYTES / ALIGN_BYTES;
   localparam int END_G = GRANULES - HDR / ALIGN_BYTES;
   localparam int NO_LINK = GRANULES;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 600;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE = 1'b1
   } heap_op_type;

   typedef struct {
      heap_op_type op;
      logic [15:0] nbytes;
      logic [11:0] addr;
   } heap_req_type;

   typedef struct {
      logic ok;
      logic [11:0] granted;
      logic [12:0] blk_bytes;
      logic [12:0] free_bytes;
   } heap_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [12:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = 1'b0;
   logic [15:0] req_request_bytes = '0;
   logic [11:0] req_user_address = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_ok;
   logic [11:0] rsp_granted_address;
   logic [12:0] rsp_block_bytes;
   logic [12:0] rsp_free_bytes;

   first_fit_heap_allocator #(
      .POOL_BYTES(POOL_BYTES),
      .ALIGN_BYTES(ALIGN_BYTES),
      .HEADER_BYTES(HEADER_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_request_bytes(req_request_bytes),
      .req_user_address(req_user_address),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ok(rsp_ok),
      .rsp_granted_address(rsp_granted_address),
      .rsp_block_bytes(rsp_block_bytes),
      .rsp_free_bytes(rsp_free_bytes)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow heap
   int unsigned hdr_size[GRANULES];
   int unsigned hdr_next[GRANULES];
   bit hdr_linked[GRANULES];
   bit hdr_alloc[GRANULES];
   int unsigned shadow_head;
   int unsigned shadow_free;
   int unsigned split_floor;

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   int unsigned live_addrs[$];
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   bit hold_off = 1'b0;
   int unsigned hold_cnt = 0;
   bit req_taken = 1'b0;

   function automatic void heap_reset();
      for (int i = 0; i < GRANULES; i++) begin
         hdr_size[i] = 0;
         hdr_next[i] = 0;
         hdr_linked[i] = 0;
         hdr_alloc[i] = 0;
      end
      hdr_size[0] = END_G * ALIGN_BYTES;
      hdr_next[0] = END_G;
      hdr_linked[0] = 1;
      shadow_head = 0;
      shadow_free = END_G * ALIGN_BYTES;
      split_floor = 16;
   endfunction

   function automatic int unsigned link_of(int unsigned n);
      if (n == NO_LINK) return shadow_head;
      if (n < GRANULES && hdr_linked[n]) return hdr_next[n];
      return NO_LINK;
   endfunction

   function automatic void relink(int unsigned n, int unsigned v);
      if (n == NO_LINK) shadow_head = v;
      else if (n < GRANULES) begin
         hdr_next[n] = v;
         hdr_linked[n] = 1;
      end
   endfunction

   function automatic void reinsert_free(int unsigned g);
      int unsigned it, blk, nx;
      it = NO_LINK;
      blk = g;
      for (int k = 0; k <= GRANULES; k++) begin
         nx = link_of(it);
         if (nx >= g || nx >= GRANULES) break;
         it = nx;
      end
      if (it != NO_LINK && it * ALIGN_BYTES + hdr_size[it] == g * ALIGN_BYTES) begin
         hdr_size[it] += hdr_size[g];
         blk = it;
      end else begin
         hdr_next[g] = link_of(it);
         hdr_linked[g] = 1;
      end
      nx = link_of(it);
      if (nx < GRANULES && nx != END_G &&
          blk * ALIGN_BYTES + hdr_size[blk] == nx * ALIGN_BYTES) begin
         hdr_size[blk] += hdr_size[nx];
         hdr_next[blk] = hdr_next[nx];
         hdr_linked[blk] = hdr_linked[nx];
      end
      if (it != blk) relink(it, blk);
   endfunction

   function automatic heap_rsp_type heap_step(heap_req_type r);
      heap_rsp_type res;
      int unsigned total, prev, blk, ng, g;
      bit found;
      res.ok = 0;
      res.granted = '0;
      res.blk_bytes = '0;
      if (r.op == OP_ALLOC) begin
         total = HDR + r.nbytes;
         if (total % ALIGN_BYTES != 0) total += ALIGN_BYTES - total % ALIGN_BYTES;
         if (r.nbytes > 0 && total <= shadow_free) begin
            prev = NO_LINK;
            blk = shadow_head;
            found = 0;
            for (int k = 0; k <= GRANULES && blk < GRANULES; k++) begin
               if (hdr_size[blk] >= total || !hdr_linked[blk]) begin
                  found = 1;
                  break;
               end
               prev = blk;
               blk = hdr_next[blk];
            end
            if (found && blk != END_G) begin
               relink(prev, hdr_linked[blk] ? hdr_next[blk] : NO_LINK);
               if (hdr_size[blk] - total > split_floor) begin
                  ng = blk + total / ALIGN_BYTES;
                  if (ng < GRANULES) begin
                     hdr_size[ng] = hdr_size[blk] - total;
                     hdr_alloc[ng] = 0;
                     hdr_linked[ng] = 0;
                     hdr_size[blk] = total;
                     reinsert_free(ng);
                  end
               end
               shadow_free -= hdr_size[blk];
               hdr_alloc[blk] = 1;
               hdr_linked[blk] = 0;
               res.ok = 1;
               res.granted = 12'(blk * ALIGN_BYTES + HDR);
               res.blk_bytes = 13'(hdr_size[blk]);
               live_addrs.push_back(blk * ALIGN_BYTES + HDR);
            end
         end
      end else if (r.addr != 0 && r.addr >= HDR && (r.addr - HDR) % ALIGN_BYTES == 0) begin
         g = (r.addr - HDR) / ALIGN_BYTES;
         if (g < GRANULES && hdr_alloc[g] && !hdr_linked[g]) begin
            hdr_alloc[g] = 0;
            res.blk_bytes = 13'(hdr_size[g]);
            shadow_free += hdr_size[g];
            reinsert_free(g);
            res.ok = 1;
         end
      end
      res.free_bytes = 13'(shadow_free);
      return res;
   endfunction

   function automatic heap_req_type make_alloc(int unsigned n);
      heap_req_type r;
      r.op = OP_ALLOC;
      r.nbytes = 16'(n);
      r.addr = 12'($urandom);
      return r;
   endfunction

   function automatic heap_req_type make_free(int unsigned a);
      heap_req_type r;
      r.op = OP_FREE;
      r.nbytes = 16'($urandom);
      r.addr = 12'(a);
      return r;
   endfunction

   function automatic int unsigned gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // mark each request transfer at the rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // driver: inputs change on the falling edge
   int unsigned drv_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            // transfer done at the last rising edge; predict and advance
            expected_rsps.push_back(heap_step(pending_reqs.pop_front()));
            drv_gap = gap_len();
         end
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && drv_gap == 0) begin
               req_valid <= 1'b1;
               req_operation <= pending_reqs[0].op;
               req_request_bytes <= pending_reqs[0].nbytes;
               req_user_address <= pending_reqs[0].addr;
            end else begin
               req_valid <= 1'b0;
               if (drv_gap > 0) drv_gap--;
            end
         end
      end
   end

   // receiver stall; a long hold-off is counted here
   always @(negedge clock) begin
      if (hold_off && hold_cnt < HOLD_CYCLES) begin
         hold_cnt++;
         rsp_stall <= 1'b1;
      end
      else if ($urandom_range(0, 29) == 0) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 3) == 0) rsp_stall <= ~rsp_stall;
      else rsp_stall <= 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      heap_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result transfer");
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_ok !== e.ok) begin
               $error("ok: expected %0d actual %0d", e.ok, rsp_ok);
               fail_count++;
            end
            if (rsp_granted_address !== e.granted) begin
               $error("granted_address: expected %0d actual %0d", e.granted,
                      rsp_granted_address);
               fail_count++;
            end
            if (rsp_block_bytes !== e.blk_bytes) begin
               $error("block_bytes: expected %0d actual %0d", e.blk_bytes, rsp_block_bytes);
               fail_count++;
            end
            if (rsp_free_bytes !== e.free_bytes) begin
               $error("free_bytes: expected %0d actual %0d", e.free_bytes, rsp_free_bytes);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_split_floor(int unsigned v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= 13'(v);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      split_floor = v;
   endtask

   task automatic random_phase(int unsigned n);
      int unsigned idx;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: pending_reqs.push_back(make_alloc($urandom));
            1: pending_reqs.push_back(make_free($urandom));
            2, 3, 4, 5: pending_reqs.push_back(
               make_alloc($urandom_range(0, 3) == 0 ? $urandom_range(1, 600)
                                                    : $urandom_range(1, 96)));
            default: begin
               if (live_addrs.size() > 0) begin
                  idx = $urandom_range(0, live_addrs.size() - 1);
                  pending_reqs.push_back(make_free(live_addrs[idx]));
                  // occasionally leave it listed to provoke a double free
                  if ($urandom_range(0, 7) != 0) live_addrs.delete(idx);
               end else pending_reqs.push_back(make_alloc($urandom_range(1, 64)));
            end
         endcase
      end
   endtask

   initial begin
      heap_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes and special cases
      pending_reqs.push_back(make_alloc(0));
      pending_reqs.push_back(make_alloc(16'hFFFF));
      pending_reqs.push_back(make_alloc(1));
      pending_reqs.push_back(make_alloc(8));
      pending_reqs.push_back(make_alloc(9));
      pending_reqs.push_back(make_alloc(100));
      pending_reqs.push_back(make_free(0));
      pending_reqs.push_back(make_free(4));
      pending_reqs.push_back(make_free(13));
      pending_reqs.push_back(make_free(12'hFFF));
      pending_reqs.push_back(make_free(16));
      pending_reqs.push_back(make_free(16));
      pending_reqs.push_back(make_free(8));
      pending_reqs.push_back(make_free(48));
      pending_reqs.push_back(make_free(24));
      pending_reqs.push_back(make_alloc(END_G * ALIGN_BYTES - HDR));
      pending_reqs.push_back(make_free(8));
      pending_reqs.push_back(make_alloc(4000));
      pending_reqs.push_back(make_alloc(80));
      wait_drained();
      live_addrs.delete();
      // rebuild tracking of directed leftovers from the shadow heap so random frees find them
      for (int g = 0; g < GRANULES; g++)
         if (hdr_alloc[g]) live_addrs.push_back(g * ALIGN_BYTES + HDR);

      // long receiver hold-off while the sender keeps offering
      random_phase(40);
      hold_off = 1'b1;
      wait (hold_cnt == HOLD_CYCLES);
      hold_off = 1'b0;
      random_phase(80);
      wait_drained();

      write_split_floor(0);
      random_phase(100);
      wait_drained();
      write_split_floor(4096);
      random_phase(60);
      wait_drained();
      write_split_floor($urandom_range(1, 8191));
      random_phase(60);
      wait_drained();
      write_split_floor(16);
      random_phase(140);
      wait_drained();

      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

[sim.f]
rtl/core/ffha_pkg.sv
rtl/core/ffha_ctrl.sv
rtl/core/ffha_datapath.sv
rtl/core/first_fit_heap_allocator.sv
sim/tb_top.sv
